[design/mcg_pkg.sv]
// Shared types, constants and pattern tables of the metronome click generator.
`default_nettype none

package mcg_pkg;

  localparam int unsigned SINE_DEPTH_DEFAULT = 256;
  localparam logic [4:0]  MAX_BEATS          = 5'd12;
  localparam int          PADDR_W            = 5;

  // configuration register indexes, at byte address 4*index
  typedef enum logic [2:0] {
    REG_BEAT_STEP     = 3'd0,
    REG_BAR_LENGTH    = 3'd1,
    REG_DIVISION_MODE = 3'd2,
    REG_CLICK_SAMPLES = 3'd3,
    REG_FADE_SCALE    = 3'd4,
    REG_TONE_DOWNBEAT = 3'd5,
    REG_TONE_BEAT     = 3'd6,
    REG_TONE_SUB      = 3'd7
  } reg_idx_t;

  localparam logic [31:0] RST_BEAT_STEP     = 32'd178957;
  localparam logic [3:0]  RST_BAR_LENGTH    = 4'd4;
  localparam logic [2:0]  RST_DIVISION_MODE = 3'd0;
  localparam logic [12:0] RST_CLICK_SAMPLES = 13'd1440;
  localparam logic [24:0] RST_FADE_SCALE    = 25'd11651;
  localparam logic [14:0] RST_TONE_DOWNBEAT = 15'd2458;
  localparam logic [14:0] RST_TONE_BEAT     = 15'd1638;
  localparam logic [14:0] RST_TONE_SUB      = 15'd1092;

  // click levels, Q0.15
  localparam logic [14:0] AMP_DOWN = 15'd26214;
  localparam logic [14:0] AMP_BEAT = 15'd16384;
  localparam logic [14:0] AMP_SUB  = 15'd8192;

  localparam logic [24:0] FADE_ONE = 25'h100_0000;

  // odd polynomial coefficients for the sine table, Q2.30
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598563;
  localparam logic [63:0] SIN_C5 = 64'd85569278;
  localparam logic [63:0] SIN_C7 = 64'd5026937;
  localparam logic [63:0] Q30    = 64'd1073741824;

  typedef struct packed {
    logic [31:0] beat_step;
    logic [3:0]  bar_length;
    logic [2:0]  division_mode;
    logic [12:0] click_samples;
    logic [24:0] fade_scale;
    logic [14:0] tone_step_downbeat;
    logic [14:0] tone_step_beat;
    logic [14:0] tone_step_sub;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic index;
    logic look;
    logic mul;
    logic scale;
    logic finish;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic play;
  } dp_status_t;

  function automatic logic [2:0] steps_of_mode(input logic [2:0] mode);
    logic [2:0] steps;
    unique case (mode)
      3'd0:    steps = 3'd1;
      3'd1:    steps = 3'd2;
      3'd2:    steps = 3'd4;
      3'd3:    steps = 3'd3;
      3'd4:    steps = 3'd4;
      3'd5:    steps = 3'd4;
      3'd6:    steps = 3'd6;
      default: steps = 3'd1;
    endcase
    return steps;
  endfunction

  function automatic logic [5:0] mask_of_mode(input logic [2:0] mode);
    logic [5:0] mask;
    unique case (mode)
      3'd0:    mask = 6'h01;
      3'd1:    mask = 6'h03;
      3'd2:    mask = 6'h0F;
      3'd3:    mask = 6'h07;
      3'd4:    mask = 6'h0D;
      3'd5:    mask = 6'h0B;
      3'd6:    mask = 6'h3F;
      default: mask = 6'h01;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

[design/metronome_click_generator_top.sv]
// Top level of the metronome click generator.
// Sequence: a sample taken while playing passes the step, index, table lookup, multiply,
// scale and finish states, a stopped one goes from step straight to done; the result
// word is loaded once the output register is free, and one word is in flight at a time.
// A waiting result word is held in the output register while the next sample is taken.
// Reset: synchronous, active high; registers to defaults, position and click cleared.
`default_nettype none

module metronome_click_generator_top
  import mcg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               playing,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      audio_out,
  output logic                    click_started,
  output logic [3:0]              shown_beat,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready = 1'b1;

  mcg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mcg_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .playing       (playing),
    .audio_out     (audio_out),
    .click_started (click_started),
    .shown_beat    (shown_beat)
  );

endmodule

`default_nettype wire

[design/mcg_regs.sv]
// Configuration register file behind the APB-style port.
`default_nettype none

module mcg_regs
  import mcg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output cfg_t                    cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beat_step          <= RST_BEAT_STEP;
      cfg.bar_length         <= RST_BAR_LENGTH;
      cfg.division_mode      <= RST_DIVISION_MODE;
      cfg.click_samples      <= RST_CLICK_SAMPLES;
      cfg.fade_scale         <= RST_FADE_SCALE;
      cfg.tone_step_downbeat <= RST_TONE_DOWNBEAT;
      cfg.tone_step_beat     <= RST_TONE_BEAT;
      cfg.tone_step_sub      <= RST_TONE_SUB;
    end else if (wr_en) begin
      unique case (idx)
        REG_BEAT_STEP:     cfg.beat_step          <= pwdata;
        REG_BAR_LENGTH:    cfg.bar_length         <= pwdata[3:0];
        REG_DIVISION_MODE: cfg.division_mode      <= pwdata[2:0];
        REG_CLICK_SAMPLES: cfg.click_samples      <= pwdata[12:0];
        REG_FADE_SCALE:    cfg.fade_scale         <= pwdata[24:0];
        REG_TONE_DOWNBEAT: cfg.tone_step_downbeat <= pwdata[14:0];
        REG_TONE_BEAT:     cfg.tone_step_beat     <= pwdata[14:0];
        REG_TONE_SUB:      cfg.tone_step_sub      <= pwdata[14:0];
        default:           cfg.beat_step          <= cfg.beat_step;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BEAT_STEP:     prdata = cfg.beat_step;
      REG_BAR_LENGTH:    prdata = 32'(cfg.bar_length);
      REG_DIVISION_MODE: prdata = 32'(cfg.division_mode);
      REG_CLICK_SAMPLES: prdata = 32'(cfg.click_samples);
      REG_FADE_SCALE:    prdata = 32'(cfg.fade_scale);
      REG_TONE_DOWNBEAT: prdata = 32'(cfg.tone_step_downbeat);
      REG_TONE_BEAT:     prdata = 32'(cfg.tone_step_beat);
      REG_TONE_SUB:      prdata = 32'(cfg.tone_step_sub);
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[design/mcg_ctrl.sv]
// Sequencer of the click generator: handshakes and datapath commands.
`default_nettype none

module mcg_ctrl
  import mcg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  dp_status_t      status,
  output dp_cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_STEP   = 8'b0000_0010,
    S_INDEX  = 8'b0000_0100,
    S_LOOK   = 8'b0000_1000,
    S_MUL    = 8'b0001_0000,
    S_SCALE  = 8'b0010_0000,
    S_FINISH = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign cmd.accept = in_valid && in_ready;
  assign cmd.step   = (state == S_STEP);
  assign cmd.index  = (state == S_INDEX);
  assign cmd.look   = (state == S_LOOK);
  assign cmd.mul    = (state == S_MUL);
  assign cmd.scale  = (state == S_SCALE);
  assign cmd.finish = (state == S_FINISH);
  assign cmd.load   = (state == S_DONE) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_STEP;
      // a stopped transport has nothing to compute
      S_STEP:   state_next = status.play ? S_INDEX : S_DONE;
      S_INDEX:  state_next = S_LOOK;
      S_LOOK:   state_next = S_MUL;
      S_MUL:    state_next = S_SCALE;
      S_SCALE:  state_next = S_FINISH;
      S_FINISH: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("result word loaded over an untaken one");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result word not presented");

  a_no_accept_on_load: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && cmd.load))
    else $error("input accepted while a result word is loaded");

  a_stopped_skips: assert property (@(posedge clk) disable iff (rst)
    cmd.step && !status.play |=> state == S_DONE)
    else $error("stopped sample went through the multiply chain");
`endif

endmodule

`default_nettype wire

[design/mcg_dp.sv]
// Datapath: beat position, step detection, sine table and click envelope.
`default_nettype none

module mcg_dp
  import mcg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  cfg_t             cfg,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  input  wire logic        playing,
  output logic signed [15:0] audio_out,
  output logic             click_started,
  output logic [3:0]       shown_beat
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int PW    = 15 + IDX_W;

  typedef logic [14:0] sine_tab_t [SINE_TABLE_DEPTH];

  // quarter-wave table, Horner evaluation in Q2.30 with truncating shifts
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] t, t2, r, s, v;
    for (int i = 0; i < int'(SINE_TABLE_DEPTH); i++) begin
      t  = (64'(2 * i + 1) << 29) / 64'(SINE_TABLE_DEPTH);
      t2 = (t * t) >> 30;
      r  = SIN_C5 - ((t2 * SIN_C7) >> 30);
      r  = SIN_C3 - ((t2 * r) >> 30);
      r  = SIN_C1 - ((t2 * r) >> 30);
      s  = (t * r) >> 30;
      v  = (s * 64'd32767 + (Q30 >> 1)) >> 30;
      tab[i] = (v > 64'd32767) ? 15'h7FFF : v[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // sample state
  logic        play_r;
  logic        was_running;
  logic [31:0] beat_fraction;
  logic [3:0]  beat_in_bar;
  logic [2:0]  last_step;
  logic        step_valid;
  logic [12:0] click_left;
  logic [15:0] tone_phase;
  logic [3:0]  latched_beat;
  logic        started_r;
  logic [15:0] audio_r;

  // multiply chain
  logic             active_r;
  logic             neg_r;
  logic [IDX_W-1:0] idx_r;
  logic [24:0]      fade_r;
  logic [14:0]      amp_r;
  logic [14:0]      inc_r;
  logic [14:0]      sine_mag_r;
  logic [29:0]      prod_r;
  logic [54:0]      mag_r;

  assign status.play = play_r;

  // step index within the beat
  logic [2:0]  steps;
  logic [5:0]  mask;
  logic [34:0] step_prod;
  logic [2:0]  step_now;
  logic        new_step;

  assign steps     = steps_of_mode(cfg.division_mode);
  assign mask      = mask_of_mode(cfg.division_mode);
  assign step_prod = 35'(beat_fraction) * 35'(steps);
  assign step_now  = step_prod[34:32];
  assign new_step  = !step_valid || (step_now != last_step);

  // table address and envelope
  logic [PW-1:0]    idx_prod;
  logic [IDX_W:0]   idx_raw;
  logic [IDX_W-1:0] idx_clamp;
  logic [IDX_W-1:0] idx_fold;
  logic [37:0]      fade_full;
  logic             downbeat;
  logic             on_beat;

  assign idx_prod  = PW'(tone_phase[13:0]) * PW'(SINE_TABLE_DEPTH);
  assign idx_raw   = idx_prod[14 +: IDX_W+1];
  assign idx_clamp = (idx_raw >= (IDX_W+1)'(SINE_TABLE_DEPTH)) ?
                     IDX_W'(SINE_TABLE_DEPTH - 1) : idx_raw[IDX_W-1:0];
  assign idx_fold  = tone_phase[14] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - idx_clamp) : idx_clamp;
  assign fade_full = 38'(click_left) * 38'(cfg.fade_scale);
  assign on_beat   = (last_step == 3'd0);
  assign downbeat  = on_beat && (beat_in_bar == 4'd0);

  // rounding, beat advance
  logic [55:0] round_sum;
  logic [16:0] rounded;
  logic [14:0] capped;
  logic [15:0] audio_val;
  logic [32:0] frac_sum;
  logic [4:0]  bar;
  logic [4:0]  beat_plus;

  assign round_sum = 56'(mag_r) + (56'd1 << 38);
  assign rounded   = round_sum[55:39];
  assign capped    = (rounded > 17'd32767) ? 15'h7FFF : rounded[14:0];
  assign audio_val = neg_r ? (16'd0 - {1'b0, capped}) : {1'b0, capped};
  assign frac_sum  = {1'b0, beat_fraction} + {1'b0, cfg.beat_step};
  assign beat_plus = {1'b0, beat_in_bar} + 5'd1;

  always_comb begin
    bar = {1'b0, cfg.bar_length};
    if (bar == 5'd0) bar = 5'd1;
    else if (bar > MAX_BEATS) bar = MAX_BEATS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_r        <= 1'b0;
      was_running   <= 1'b0;
      beat_fraction <= 32'd0;
      beat_in_bar   <= 4'd0;
      last_step     <= 3'd0;
      step_valid    <= 1'b0;
      click_left    <= 13'd0;
      tone_phase    <= 16'd0;
      latched_beat  <= 4'd0;
      started_r     <= 1'b0;
      audio_r       <= 16'd0;
      active_r      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        play_r      <= playing;
        was_running <= playing;
        started_r   <= 1'b0;
        audio_r     <= 16'd0;
        // rewind on start of play
        if (playing && !was_running) begin
          beat_fraction <= 32'd0;
          beat_in_bar   <= 4'd0;
          step_valid    <= 1'b0;
        end
        if (!playing) begin
          step_valid <= 1'b0;
          click_left <= 13'd0;
        end
      end
      if (cmd.step && play_r && new_step) begin
        last_step  <= step_now;
        step_valid <= 1'b1;
        if (mask[step_now]) begin
          latched_beat <= beat_in_bar;
          click_left   <= cfg.click_samples;
          tone_phase   <= 16'd0;
          started_r    <= 1'b1;
        end
      end
      if (cmd.index) begin
        active_r <= (click_left != 13'd0);
      end
      if (cmd.finish) begin
        if (active_r) begin
          audio_r    <= audio_val;
          tone_phase <= tone_phase + 16'(inc_r);
          click_left <= click_left - 13'd1;
        end
        beat_fraction <= frac_sum[31:0];
        if (frac_sum[32]) begin
          beat_in_bar <= (beat_plus >= bar) ? 4'd0 : beat_plus[3:0];
          step_valid  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.index) begin
      idx_r  <= idx_fold;
      neg_r  <= tone_phase[15];
      fade_r <= (fade_full > 38'(FADE_ONE)) ? FADE_ONE : fade_full[24:0];
      if (downbeat) begin
        amp_r <= AMP_DOWN;
        inc_r <= cfg.tone_step_downbeat;
      end else if (on_beat) begin
        amp_r <= AMP_BEAT;
        inc_r <= cfg.tone_step_beat;
      end else begin
        amp_r <= AMP_SUB;
        inc_r <= cfg.tone_step_sub;
      end
    end
    if (cmd.look)  sine_mag_r <= SINE_TAB[idx_r];
    if (cmd.mul)   prod_r     <= 30'(sine_mag_r) * 30'(amp_r);
    if (cmd.scale) mag_r      <= 55'(prod_r) * 55'(fade_r);
    if (cmd.load) begin
      audio_out     <= audio_r;
      click_started <= started_r;
      shown_beat    <= latched_beat;
    end
  end

endmodule

`default_nettype wire

[verif/tb_metronome_click_generator_top.sv]
// Self-checking testbench for the metronome click generator: predicts and checks every word.
`timescale 1ns / 100ps

module tb_metronome_click_generator_top;
  import mcg_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SEGMENTS     = 12;
  localparam int SEG_WORDS    = 163;
  localparam int HOLD_SEG     = 4;
  localparam int TOP_SEG      = 5;
  localparam int BOTTOM_SEG   = 9;
  localparam int TABLE_DEPTH  = int'(SINE_DEPTH_DEFAULT);

  typedef enum logic [2:0] {
    DIV_QUARTER, DIV_EIGHTH, DIV_SIXTEENTH, DIV_TRIPLET,
    DIV_GALLOP, DIV_REV_GALLOP, DIV_SEXTOLET, DIV_SPARE
  } div_mode_t;

  class click_scoreboard;
    typedef struct packed {
      logic signed [15:0] audio;
      logic               started;
      logic [3:0]         beat;
    } click_word_t;

    bit [31:0] beat_step;
    bit [3:0]  bar_length;
    bit [2:0]  division_mode;
    bit [12:0] click_samples;
    bit [24:0] fade_scale;
    bit [14:0] tone_down, tone_beat, tone_sub;

    bit [31:0] frac;
    bit [3:0]  beat;
    bit [2:0]  last_step;
    bit        step_seen;
    bit        was_playing;
    bit [12:0] click_left;
    bit [15:0] phase;
    bit [3:0]  latched;
    bit [15:0] quarter_sine[TABLE_DEPTH];

    click_word_t words_due[$];
    int mismatches;
    int words_checked;
    int samples_taken;
    int clicks_due;

    function new();
      longint unsigned t, t2, r, s, v;
      beat_step     = RST_BEAT_STEP;
      bar_length    = RST_BAR_LENGTH;
      division_mode = RST_DIVISION_MODE;
      click_samples = RST_CLICK_SAMPLES;
      fade_scale    = RST_FADE_SCALE;
      tone_down     = RST_TONE_DOWNBEAT;
      tone_beat     = RST_TONE_BEAT;
      tone_sub      = RST_TONE_SUB;
      // quarter-wave table: odd polynomial in Q2.30, Horner with truncation
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        t  = (longint'(2 * i + 1) << 29) / TABLE_DEPTH;
        t2 = (t * t) >> 30;
        r  = SIN_C5 - ((t2 * SIN_C7) >> 30);
        r  = SIN_C3 - ((t2 * r) >> 30);
        r  = SIN_C1 - ((t2 * r) >> 30);
        s  = (t * r) >> 30;
        v  = (s * 64'd32767 + (Q30 >> 1)) >> 30;
        quarter_sine[i] = (v > 64'd32767) ? 16'd32767 : v[15:0];
      end
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_BEAT_STEP:     beat_step     = val;
        REG_BAR_LENGTH:    bar_length    = val[3:0];
        REG_DIVISION_MODE: division_mode = val[2:0];
        REG_CLICK_SAMPLES: click_samples = val[12:0];
        REG_FADE_SCALE:    fade_scale    = val[24:0];
        REG_TONE_DOWNBEAT: tone_down     = val[14:0];
        REG_TONE_BEAT:     tone_beat     = val[14:0];
        REG_TONE_SUB:      tone_sub      = val[14:0];
        default: ;
      endcase
    endfunction

    function int sine_at(bit [15:0] ph);
      int idx;
      int v;
      idx = (int'(ph[13:0]) * TABLE_DEPTH) >> 14;
      if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
      if (ph[14]) idx = TABLE_DEPTH - 1 - idx;
      v = int'(quarter_sine[idx]);
      return ph[15] ? -v : v;
    endfunction

    function void note_sample(logic play);
      click_word_t w;
      int steps, bar, amp;
      bit [5:0] mask;
      bit [14:0] inc;
      bit [2:0] cur_step;
      bit [32:0] nxt;
      longint unsigned wide, fade, mag;
      longint prod;
      w = '0;
      samples_taken++;
      if (play && !was_playing) begin
        frac = 0;
        beat = 0;
        step_seen = 0;
      end
      was_playing = play;
      if (!play) begin
        step_seen = 0;
        click_left = 0;
      end else begin
        case (div_mode_t'(division_mode))
          DIV_EIGHTH:     begin steps = 2; mask = 6'h03; end
          DIV_SIXTEENTH:  begin steps = 4; mask = 6'h0F; end
          DIV_TRIPLET:    begin steps = 3; mask = 6'h07; end
          DIV_GALLOP:     begin steps = 4; mask = 6'h0D; end
          DIV_REV_GALLOP: begin steps = 4; mask = 6'h0B; end
          DIV_SEXTOLET:   begin steps = 6; mask = 6'h3F; end
          default:        begin steps = 1; mask = 6'h01; end
        endcase
        wide = frac;
        wide = (wide * steps) >> 32;
        cur_step = wide[2:0];
        bar = bar_length;
        if (bar < 1) bar = 1;
        if (bar > 12) bar = 12;

        if (!step_seen || cur_step != last_step) begin
          last_step = cur_step;
          step_seen = 1;
          if (mask[cur_step]) begin
            latched = beat;
            click_left = click_samples;
            phase = 0;
            w.started = 1'b1;
            clicks_due++;
          end
        end

        if (click_left != 0) begin
          if (last_step == 0 && beat == 0) begin
            amp = AMP_DOWN;
            inc = tone_down;
          end else if (last_step == 0) begin
            amp = AMP_BEAT;
            inc = tone_beat;
          end else begin
            amp = AMP_SUB;
            inc = tone_sub;
          end
          fade = longint'(click_left) * longint'(fade_scale);
          if (fade > 64'h100_0000) fade = 64'h100_0000;
          prod = longint'(sine_at(phase)) * longint'(amp);
          mag = ((prod < 0) ? -prod : prod) * fade;
          mag = (mag + (64'd1 << 38)) >> 39;
          if (mag > 64'd32767) mag = 64'd32767;
          w.audio = mag[15:0];
          if (prod < 0) w.audio = -w.audio;
          phase = phase + inc;
          click_left = click_left - 1;
        end

        // carry out of the fraction moves to the next beat
        nxt = {1'b0, frac} + {1'b0, beat_step};
        if (nxt[32]) begin
          beat = (int'(beat) + 1 >= bar) ? 4'd0 : beat + 4'd1;
          step_seen = 0;
        end
        frac = nxt[31:0];
      end
      w.beat = latched;
      words_due.insert(words_due.size(), w);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 20) $display("MISMATCH at word %0d: %s", words_checked, what);
    endtask

    task check_word(logic signed [15:0] audio, logic started, logic [3:0] shown);
      click_word_t w;
      if (words_due.size() == 0) begin
        report("result word with nothing predicted");
      end else begin
        w = words_due.pop_front();
        if (audio !== w.audio)
          report($sformatf("audio_out %0d, predicted %0d", audio, w.audio));
        if (started !== w.started)
          report($sformatf("click_started %0b, predicted %0b", started, w.started));
        if (shown !== w.beat)
          report($sformatf("shown_beat %0d, predicted %0d", shown, w.beat));
      end
      words_checked++;
    endtask

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic playing = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] audio_out;
  logic click_started;
  logic [3:0] shown_beat;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  click_scoreboard sb;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  metronome_click_generator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .playing(playing),
    .out_valid(out_valid), .out_ready(out_ready),
    .audio_out(audio_out), .click_started(click_started), .shown_beat(shown_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: a long hold-off takes priority over random stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_sample(playing);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(audio_out, click_started, shown_beat);
  end

  // hold valid high across back-to-back words; drop it only for a gap
  task automatic offer_sample(input logic p);
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    in_valid <= 1'b1;
    playing <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic directed_part();
    // defaults: a stopped word, then the downbeat click
    offer_sample(1'b0);
    offer_sample(1'b1);
    offer_sample(1'b1);
    settle();
    // four words per beat, bar of zero acts as one, spare division code
    write_reg(REG_BEAT_STEP, 32'h4000_0000);
    write_reg(REG_BAR_LENGTH, 32'd0);
    write_reg(REG_DIVISION_MODE, 32'(DIV_SPARE));
    write_reg(REG_CLICK_SAMPLES, 32'd2);
    write_reg(REG_FADE_SCALE, 32'h80_0000);
    repeat (5) offer_sample(1'b1);
    settle();
    // bar beyond the maximum, fastest position, clicks of no length
    write_reg(REG_BEAT_STEP, 32'hFFFF_FFFF);
    write_reg(REG_BAR_LENGTH, 32'd15);
    write_reg(REG_DIVISION_MODE, 32'(DIV_SEXTOLET));
    write_reg(REG_CLICK_SAMPLES, 32'd0);
    repeat (3) offer_sample(1'b1);
    settle();
    // longest click, oversized fade, extreme pitches, stop and restart
    write_reg(REG_BEAT_STEP, 32'h2000_0000);
    write_reg(REG_DIVISION_MODE, 32'(DIV_GALLOP));
    write_reg(REG_CLICK_SAMPLES, 32'd8191);
    write_reg(REG_FADE_SCALE, 32'h1FF_FFFF);
    write_reg(REG_TONE_DOWNBEAT, 32'h7FFF);
    write_reg(REG_TONE_BEAT, 32'd0);
    write_reg(REG_TONE_SUB, 32'h7FFF);
    offer_sample(1'b1);
    offer_sample(1'b1);
    offer_sample(1'b1);
    offer_sample(1'b0);
    offer_sample(1'b1);
    settle();
    // shorten the click while the long one sounds; position stands still
    write_reg(REG_CLICK_SAMPLES, 32'd1);
    write_reg(REG_FADE_SCALE, 32'h100_0000);
    write_reg(REG_BEAT_STEP, 32'd0);
    offer_sample(1'b1);
    offer_sample(1'b1);
    settle();
    // every division code, changed mid-beat
    write_reg(REG_BEAT_STEP, 32'h3000_0000);
    for (int m = DIV_QUARTER; m <= DIV_SPARE; m++) begin
      write_reg(REG_DIVISION_MODE, 32'(m));
      offer_sample(1'b1);
      settle();
    end
  endtask

  task automatic pick_settings(input int seg);
    logic [31:0] bstep;
    logic [3:0]  bar;
    logic [2:0]  mode;
    logic [12:0] clen;
    logic [24:0] fscale;
    logic [14:0] tdown, tbeat, tsub;
    if (seg == TOP_SEG) begin
      bstep = 32'hFFFF_FFFF;
      bar = 4'd12;
      mode = DIV_SEXTOLET;
      clen = 13'h1FFF;
      fscale = 25'h100_0000;
      tdown = 15'h7FFF;
      tbeat = 15'h7FFF;
      tsub = 15'h7FFF;
    end else if (seg == BOTTOM_SEG) begin
      bstep = 32'd1;
      bar = 4'd1;
      mode = DIV_QUARTER;
      clen = 13'd1;
      fscale = 25'd1;
      tdown = '0;
      tbeat = '0;
      tsub = '0;
    end else begin
      bstep = $urandom_range(32'h2000_0000, 32'h0400_0000);
      bar = ($urandom_range(99) < 80) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(0, 15));
      mode = 3'($urandom_range(0, 7));
      clen = ($urandom_range(99) < 90) ? 13'($urandom_range(1, 24)) : 13'd0;
      if ($urandom_range(99) < 75 && clen != 0) fscale = 25'(32'h100_0000 / clen);
      else fscale = 25'($urandom);
      tdown = 15'($urandom_range(0, 32767));
      tbeat = 15'($urandom_range(0, 32767));
      tsub = 15'($urandom_range(0, 32767));
    end
    write_reg(REG_BEAT_STEP, bstep);
    write_reg(REG_BAR_LENGTH, 32'(bar));
    write_reg(REG_DIVISION_MODE, 32'(mode));
    write_reg(REG_CLICK_SAMPLES, 32'(clen));
    write_reg(REG_FADE_SCALE, 32'(fscale));
    write_reg(REG_TONE_DOWNBEAT, 32'(tdown));
    write_reg(REG_TONE_BEAT, 32'(tbeat));
    write_reg(REG_TONE_SUB, 32'(tsub));
  endtask

  task automatic run_segment(input int seg);
    int stop_left;
    logic p;
    stop_left = 0;
    for (int k = 0; k < SEG_WORDS; k++) begin
      if (seg == HOLD_SEG && k == 40) hold_left = 400;
      // mostly playing, with short stops to force rewinds
      if (stop_left != 0) begin
        p = 1'b0;
        stop_left--;
      end else if ($urandom_range(99) < 4) begin
        p = 1'b0;
        stop_left = $urandom_range(0, 5);
      end else begin
        p = 1'b1;
      end
      offer_sample(p);
    end
    settle();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part();
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      pick_settings(seg);
      case (seg % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 77; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 77; end
        default: begin in_gap_pct = 30; out_stall_pct = 30; end
      endcase
      run_segment(seg);
    end
    $display("Run: %0d samples, %0d words checked, %0d clicks started, %0d mismatches",
             sb.samples_taken, sb.words_checked, sb.clicks_due, sb.mismatches);
    $display("Covered all division codes, bar lengths 0 to 15, empty and longest clicks, %s",
             "saturated fade, stop/restart and a long output hold-off");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/mcg_pkg.sv
design/mcg_regs.sv
design/mcg_ctrl.sv
design/mcg_dp.sv
design/metronome_click_generator_top.sv
verif/tb_metronome_click_generator_top.sv
